// File: src/dual_motor_encoder_pid_speed_top_assert.svh
// assertion macros for the motor speed controller
`ifndef DUAL_MOTOR_ENCODER_PID_SPEED_TOP_ASSERT_SVH
`define DUAL_MOTOR_ENCODER_PID_SPEED_TOP_ASSERT_SVH

// a condition implies another in the next cycle
`define DMP_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

// a condition implies another in the same cycle
`define DMP_ASSERT_NOW(label, clk, rst_n, cond, now, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (now)) \
        else $error(msg);

`endif

// File: src/dmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_pkg
// shared types and constants of the two-motor speed controller
// ----------------------------------------------------------------------------
package dmp_pkg;

    localparam logic [1:0] CMD_EDGE   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_PWM    = 2'd2;
    localparam logic [1:0] CMD_TARGET = 2'd3;

    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_MIN_INT   = 3'd3;
    localparam logic [2:0] REG_CPR       = 3'd4;
    localparam logic [2:0] REG_INT_LIMIT = 3'd5;
    localparam logic [2:0] REG_SLEW      = 3'd6;

    localparam int QDEPTH = 2;
    localparam logic [23:0] RPM_SCALE = 24'd15360000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               motor_id;
        logic               phase_b;
        logic [31:0]        now_ms;
        logic signed [15:0] pwm_value;
        logic signed [23:0] target_speed;
    } t_item;

    typedef struct packed {
        logic [7:0]         duty_left;
        logic               reverse_left;
        logic [7:0]         duty_right;
        logic               reverse_right;
        logic signed [23:0] speed_left;
        logic signed [23:0] speed_right;
        logic               speed_mode;
        logic               updated;
    } t_result;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [9:0]  min_interval;
        logic [15:0] cpr;
        logic [7:0]  int_limit;
        logic [7:0]  slew;
        logic        clear_pid;
    } t_cfg;

endpackage

// File: src/dual_motor_encoder_pid_speed_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_encoder_pid_speed_top
// two-motor encoder speed measurement and pid speed control
// ----------------------------------------------------------------------------
// channel  direction  handshake
// input    in         i_valid / o_ready
// output   out        o_valid / i_ready
// config   in         i_cfg_we, no wait
//
// edge, set pwm and set target items pass through the decide and output states of the sequencer
// a speed update runs per motor two multiply steps, a 56-step
// division and a filter step
// speed mode adds the pid steps for each motor on the shared multiplier
// a two-entry fifo takes items while the sequencer is busy
// reset is synchronous; control state clears, registers load their defaults
// ----------------------------------------------------------------------------
module dual_motor_encoder_pid_speed_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic        i_motor_id,
    input  logic        i_phase_b,
    input  logic [31:0] i_now_ms,
    input  logic signed [15:0] i_pwm_value,
    input  logic signed [23:0] i_target_speed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_duty_left,
    output logic        o_reverse_left,
    output logic [7:0]  o_duty_right,
    output logic        o_reverse_right,
    output logic signed [23:0] o_speed_left,
    output logic signed [23:0] o_speed_right,
    output logic        o_speed_mode,
    output logic        o_updated,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    `include "dual_motor_encoder_pid_speed_top_assert.svh"

    dmp_pkg::t_cfg r_cfg;
    dmp_pkg::t_item in_item, q_item;
    dmp_pkg::t_result res;
    logic q_valid, q_ready;

    assign in_item.cmd = i_cmd;
    assign in_item.motor_id = i_motor_id;
    assign in_item.phase_b = i_phase_b;
    assign in_item.now_ms = i_now_ms;
    assign in_item.pwm_value = i_pwm_value;
    assign in_item.target_speed = i_target_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p <= 16'd2458;
            r_cfg.gain_i <= 16'd1638;
            r_cfg.gain_d <= 16'd4096;
            r_cfg.min_interval <= 10'd5;
            r_cfg.cpr <= 16'd432;
            r_cfg.int_limit <= 8'd255;
            r_cfg.slew <= 8'd50;
            r_cfg.clear_pid <= 1'b0;
        end else begin
            r_cfg.clear_pid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dmp_pkg::REG_GAIN_P: begin
                        r_cfg.gain_p <= i_cfg_data; r_cfg.clear_pid <= 1'b1;
                    end
                    dmp_pkg::REG_GAIN_I: begin
                        r_cfg.gain_i <= i_cfg_data; r_cfg.clear_pid <= 1'b1;
                    end
                    dmp_pkg::REG_GAIN_D: begin
                        r_cfg.gain_d <= i_cfg_data; r_cfg.clear_pid <= 1'b1;
                    end
                    dmp_pkg::REG_MIN_INT:   r_cfg.min_interval <= i_cfg_data[9:0];
                    dmp_pkg::REG_CPR:       r_cfg.cpr <= i_cfg_data;
                    dmp_pkg::REG_INT_LIMIT: r_cfg.int_limit <= i_cfg_data[7:0];
                    dmp_pkg::REG_SLEW:      r_cfg.slew <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    dmp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    dmp_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(res)
    );

    assign o_duty_left = res.duty_left;
    assign o_reverse_left = res.reverse_left;
    assign o_duty_right = res.duty_right;
    assign o_reverse_right = res.reverse_right;
    assign o_speed_left = res.speed_left;
    assign o_speed_right = res.speed_right;
    assign o_speed_mode = res.speed_mode;
    assign o_updated = res.updated;

    `DMP_ASSERT_NOW(a_duty_sign_left, i_clk, i_rst_n, o_valid && o_reverse_left,
        o_duty_left != 8'd0, "negative left pwm with zero duty")
    `DMP_ASSERT_NOW(a_duty_sign_right, i_clk, i_rst_n, o_valid && o_reverse_right,
        o_duty_right != 8'd0, "negative right pwm with zero duty")
    `DMP_ASSERT_NEXT(a_queue_take, i_clk, i_rst_n, q_valid && q_ready,
        !q_ready, "sequencer took a second item at once")
endmodule

// File: src/dmp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_queue
// front end: accepts items into a short fifo for the back end
// ----------------------------------------------------------------------------
module dmp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dmp_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output dmp_pkg::t_item o_item
);
    dmp_pkg::t_item r_mem [dmp_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 2'(dmp_pkg::QDEPTH);
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: src/dmp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_div
// radix-2 restoring divider, 56-bit dividend by 48-bit divisor
// ----------------------------------------------------------------------------
module dmp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [55:0] i_num,
    input  logic [47:0] i_den,
    output logic        o_done,
    output logic [55:0] o_quot
);
    logic [55:0] r_q;
    logic [48:0] r_rem;
    logic [47:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [48:0] shifted;
    logic [49:0] diff;

    assign shifted = {r_rem[47:0], r_q[55]};
    assign diff = {1'b0, shifted} - {2'b0, r_den};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= 6'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_q <= i_num;
                r_rem <= 49'd0;
                r_den <= i_den;
                r_cnt <= 6'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!diff[49]) begin
                    r_rem <= diff[48:0];
                    r_q <= {r_q[54:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_q <= {r_q[54:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd55) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: src/dmp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_core
// back end: sequencer that runs edges, pwm and target items, speed updates and pid steps
// ----------------------------------------------------------------------------
module dmp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dmp_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  dmp_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output dmp_pkg::t_result o_res
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_MUL1, S_MUL2, S_DIV, S_FILT,
        S_PI, S_PP, S_PD, S_PSUM, S_PCLAMP, S_NEXT, S_OUT
    } t_state;

    t_state r_state;
    dmp_pkg::t_item r_it;
    logic [31:0] r_cnt [2];
    logic [31:0] r_prev [2];
    logic [31:0] r_last;
    logic signed [23:0] r_spd [2];
    logic signed [23:0] r_want [2];
    logic signed [8:0]  r_drv [2];
    logic signed [16:0] r_int [2];
    logic signed [24:0] r_perr [2];
    logic r_mode, r_upd, r_m, r_neg;
    logic [31:0] r_dt, r_mag;
    logic [47:0] r_den;
    logic [55:0] r_num;
    logic r_dstart;
    logic signed [25:0] r_err;
    logic signed [42:0] r_acc;
    logic signed [42:0] r_prod;

    logic div_done;
    logic [55:0] quot;
    logic [31:0] dt_w, delta;
    logic [9:0] mi;
    logic [15:0] cpr;
    logic signed [25:0] lim, dif;
    logic signed [24:0] rpm, fd;
    logic signed [42:0] out_lo, out_hi, oc, ocm;
    logic signed [34:0] tr;
    logic signed [42:0] isum;
    logic signed [16:0] opwm;

    dmp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_num), .i_den(r_den), .o_done(div_done), .o_quot(quot)
    );

    assign dt_w = r_it.now_ms - r_last;
    assign delta = r_cnt[r_m] - r_prev[r_m];
    assign mi = (i_cfg.min_interval == 10'd0) ? 10'd1 : i_cfg.min_interval;
    assign cpr = (i_cfg.cpr == 16'd0) ? 16'd1 : i_cfg.cpr;
    assign o_ready = r_state == S_IDLE;

    // saturate then restore sign; also the filter, pid and slew clamp terms
    always_comb begin
        if (quot > 56'd8388608) begin
            rpm = r_neg ? -25'sd8388608 : 25'sd8388607;
        end else if (quot == 56'd8388608) begin
            rpm = r_neg ? -25'sd8388608 : 25'sd8388607;
        end else begin
            rpm = r_neg ? -$signed({1'b0, quot[23:0]}) : $signed({1'b0, quot[23:0]});
        end
        fd = $signed(25'((rpm - 25'(r_spd[r_m])) >>> 1));
        lim = $signed({10'd0, i_cfg.int_limit, 8'd0});
        dif = 26'(r_err) - 26'(r_perr[r_m]);
        isum = 43'(r_int[r_m]) + (r_prod >>> 12);
        out_lo = 43'(($signed(17'(r_drv[r_m])) - $signed({9'd0, i_cfg.slew})) * 256);
        out_hi = 43'(($signed(17'(r_drv[r_m])) + $signed({9'd0, i_cfg.slew})) * 256);
        oc = (r_acc < out_lo) ? out_lo : ((r_acc > out_hi) ? out_hi : r_acc);
        ocm = oc[42] ? -oc : oc;
        tr = ocm[42:8];
        opwm = (tr > 35'sd255) ? 17'sd255 : 17'(tr);
        if (oc[42]) opwm = -opwm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_dstart <= 1'b0;
            r_mode <= 1'b0;
            r_last <= 32'd0;
            for (int k = 0; k < 2; k++) begin
                r_cnt[k] <= 32'd0; r_prev[k] <= 32'd0; r_spd[k] <= 24'sd0;
                r_want[k] <= 24'sd0; r_drv[k] <= 9'sd0; r_int[k] <= 17'sd0;
                r_perr[k] <= 25'sd0;
            end
        end else begin
            r_dstart <= 1'b0;
            if (o_valid && i_ready && r_state != S_OUT) o_valid <= 1'b0;
            if (i_cfg.clear_pid) begin
                for (int k = 0; k < 2; k++) begin
                    r_int[k] <= 17'sd0; r_perr[k] <= 25'sd0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_it <= i_item;
                        r_upd <= 1'b0;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    unique case (r_it.cmd)
                        dmp_pkg::CMD_EDGE: begin
                            if (r_it.phase_b ^ r_it.motor_id)
                                r_cnt[r_it.motor_id] <= r_cnt[r_it.motor_id] - 32'd1;
                            else
                                r_cnt[r_it.motor_id] <= r_cnt[r_it.motor_id] + 32'd1;
                            r_state <= S_OUT;
                        end
                        dmp_pkg::CMD_UPDATE: begin
                            if (!dt_w[31] && dt_w >= 32'(mi)) begin
                                r_last <= r_it.now_ms;
                                r_dt <= dt_w;
                                r_upd <= 1'b1;
                                r_m <= 1'b0;
                                r_state <= S_MUL1;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        dmp_pkg::CMD_PWM: begin
                            r_mode <= 1'b0;
                            if (r_it.pwm_value > 16'sd255)
                                r_drv[r_it.motor_id] <= 9'sd255;
                            else if (r_it.pwm_value < -16'sd255)
                                r_drv[r_it.motor_id] <= -9'sd255;
                            else
                                r_drv[r_it.motor_id] <= 9'(r_it.pwm_value);
                            r_state <= S_OUT;
                        end
                        dmp_pkg::CMD_TARGET: begin
                            r_mode <= 1'b1;
                            r_want[r_it.motor_id] <= r_it.target_speed;
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_MUL1: begin
                    r_neg <= delta[31];
                    r_mag <= delta[31] ? -delta : delta;
                    r_den <= r_dt * cpr;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_num <= r_mag * dmp_pkg::RPM_SCALE;
                    r_dstart <= 1'b1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) r_state <= S_FILT;
                end
                S_FILT: begin
                    r_spd[r_m] <= 24'(25'(r_spd[r_m]) + fd);
                    r_prev[r_m] <= r_cnt[r_m];
                    if (r_m == 1'b0) begin
                        r_m <= 1'b1;
                        r_state <= S_MUL1;
                    end else if (r_mode) begin
                        r_m <= 1'b0;
                        r_state <= S_PI;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_PI: begin
                    r_err <= 26'(r_want[r_m]) - 26'(r_spd[r_m]);
                    r_state <= S_PP;
                end
                S_PP: begin
                    r_prod <= r_err * $signed({1'b0, i_cfg.gain_i});
                    r_state <= S_PD;
                end
                S_PD: begin
                    if (isum > 43'(lim)) r_int[r_m] <= 17'(lim);
                    else if (isum < -43'(lim)) r_int[r_m] <= 17'(-lim);
                    else r_int[r_m] <= 17'(isum);
                    r_prod <= r_err * $signed({1'b0, i_cfg.gain_p});
                    r_state <= S_PSUM;
                end
                S_PSUM: begin
                    r_acc <= (r_prod >>> 12) + 43'(r_int[r_m]);
                    r_prod <= dif * $signed({1'b0, i_cfg.gain_d});
                    r_state <= S_PCLAMP;
                end
                S_PCLAMP: begin
                    r_acc <= r_acc + (r_prod >>> 12);
                    r_perr[r_m] <= 25'(r_err);
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_drv[r_m] <= 9'(opwm);
                    if (r_m == 1'b0) begin
                        r_m <= 1'b1;
                        r_state <= S_PI;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_res.duty_left <= 8'(r_drv[0][8] ? -r_drv[0] : r_drv[0]);
                        o_res.reverse_left <= r_drv[0][8];
                        o_res.duty_right <= 8'(r_drv[1][8] ? -r_drv[1] : r_drv[1]);
                        o_res.reverse_right <= r_drv[1][8];
                        o_res.speed_left <= r_spd[0];
                        o_res.speed_right <= r_spd[1];
                        o_res.speed_mode <= r_mode;
                        o_res.updated <= r_upd;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
